@@ hw/rtl/ptst_pkg.sv @@
// ----------------------------------------------------------------------------
// ptst_pkg: shared types for the periodic timer slot table
// Operation and compare codes, and the command word sent to the slot bank.
// ----------------------------------------------------------------------------
package ptst_pkg;

   typedef enum logic [2:0] {
      OP_TICK         = 3'd0,
      OP_ADD          = 3'd1,
      OP_REMOVE       = 3'd2,
      OP_SET_ENABLE   = 3'd3,
      OP_SET_INTERVAL = 3'd4,
      OP_QUERY        = 3'd5,
      OP_COMPARE      = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      CMP_EQ = 3'd0,
      CMP_LT = 3'd1,
      CMP_LE = 3'd2,
      CMP_GT = 3'd3,
      CMP_GE = 3'd4
   } cmp_mode_type;

   localparam int unsigned TimeW   = 32;
   localparam int unsigned FireW   = 8;
   localparam int unsigned HandleW = 3;

   typedef struct packed {
      logic             tick;
      logic             alloc;
      logic             free;
      logic             set_enable;
      logic             set_period;
      logic             enable_value;
      logic [TimeW-1:0] period_value;
   } bank_cmd_type;

endpackage

@@ hw/rtl/ptst_free_stack.sv @@
// ----------------------------------------------------------------------------
// ptst_free_stack: LIFO of free slot handles
// Pops a handle for an add and pushes one back for a remove, one per cycle.
// ----------------------------------------------------------------------------
module ptst_free_stack #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop,
   input  logic                 push,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] push_slot,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] top_slot,
   output logic                 can_pop,
   output logic                 can_push
);

   localparam int SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CountW = $clog2(SLOT_COUNT + 1);

   logic [SlotW-1:0]  stack_ff [SLOT_COUNT];
   logic [SlotW-1:0]  stack_in [SLOT_COUNT];
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic [CountW-1:0] top_idx;

   assign top_idx  = count_ff - CountW'(1);
   assign top_slot = stack_ff[top_idx[SlotW-1:0]];
   assign can_pop  = (count_ff != '0);
   assign can_push = (count_ff != CountW'(SLOT_COUNT));

   always_comb begin
      stack_in = stack_ff;
      count_in = count_ff;
      if (pop) begin
         count_in = top_idx;
      end else if (push) begin
         stack_in[count_ff[SlotW-1:0]] = push_slot;
         count_in = count_ff + CountW'(1);
      end
   end

   // After reset handle 0 sits on top of the stack.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            stack_ff[i] <= SlotW'(SLOT_COUNT - 1 - i);
         end
         count_ff <= CountW'(SLOT_COUNT);
      end else begin
         stack_ff <= stack_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hw/rtl/ptst_slot_bank.sv @@
// ----------------------------------------------------------------------------
// ptst_slot_bank: per-slot period, countdown and status
// Holds every slot's state and runs all countdowns in parallel on a tick.
// ----------------------------------------------------------------------------
module ptst_slot_bank #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptst_pkg::bank_cmd_type        cmd,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] alloc_slot,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] sel_slot,
   output logic                          sel_in_use,
   output logic                          sel_enabled,
   output logic [ptst_pkg::TimeW-1:0]    sel_period,
   output logic [ptst_pkg::FireW-1:0]    fire_mask
);

   localparam int TimeW = ptst_pkg::TimeW;

   logic [SLOT_COUNT-1:0] in_use_ff;
   logic [SLOT_COUNT-1:0] in_use_in;
   logic [SLOT_COUNT-1:0] enabled_ff;
   logic [SLOT_COUNT-1:0] enabled_in;
   logic [SLOT_COUNT-1:0] expire;
   logic [TimeW-1:0]      period_ff [SLOT_COUNT];
   logic [TimeW-1:0]      period_in [SLOT_COUNT];
   logic [TimeW-1:0]      remain_ff [SLOT_COUNT];
   logic [TimeW-1:0]      remain_in [SLOT_COUNT];

   assign sel_in_use  = in_use_ff[sel_slot];
   assign sel_enabled = enabled_ff[sel_slot];
   assign sel_period  = period_ff[sel_slot];

   // A count of one reaches zero on this tick, so the slot reloads instead.
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         expire[i] = cmd.tick && in_use_ff[i] && (remain_ff[i] == TimeW'(1));
      end
   end

   always_comb begin
      in_use_in  = in_use_ff;
      enabled_in = enabled_ff;
      period_in  = period_ff;
      remain_in  = remain_ff;
      if (cmd.tick) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (expire[i]) begin
               remain_in[i] = period_ff[i];
            end else if (in_use_ff[i]) begin
               remain_in[i] = remain_ff[i] - TimeW'(1);
            end
         end
      end
      if (cmd.alloc) begin
         in_use_in[alloc_slot]  = 1'b1;
         enabled_in[alloc_slot] = cmd.enable_value;
         period_in[alloc_slot]  = cmd.period_value;
         remain_in[alloc_slot]  = cmd.period_value;
      end
      if (cmd.free) begin
         in_use_in[sel_slot] = 1'b0;
      end
      if (cmd.set_enable) begin
         enabled_in[sel_slot] = cmd.enable_value;
      end
      if (cmd.set_period) begin
         period_in[sel_slot] = cmd.period_value;
      end
   end

   genvar b;
   generate
      for (b = 0; b < ptst_pkg::FireW; b++) begin : g_fire
         if (b < SLOT_COUNT) begin : g_live
            assign fire_mask[b] = expire[b] && enabled_ff[b];
         end else begin : g_none
            assign fire_mask[b] = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         enabled_ff <= '0;
      end else begin
         in_use_ff  <= in_use_in;
         enabled_ff <= enabled_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      remain_ff <= remain_in;
   end

endmodule

@@ hw/rtl/ptst_timebase.sv @@
// ----------------------------------------------------------------------------
// ptst_timebase: 64-bit millisecond timestamp and probe comparator
// Tick word with carry into the epoch word, and a compare against now.
// ----------------------------------------------------------------------------
module ptst_timebase (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  ptst_pkg::cmp_mode_type     mode,
   input  logic [ptst_pkg::TimeW-1:0] probe_epochs,
   input  logic [ptst_pkg::TimeW-1:0] probe_ticks,
   output logic [ptst_pkg::TimeW-1:0] now_epochs,
   output logic [ptst_pkg::TimeW-1:0] now_ticks,
   output logic                       compare_true
);

   localparam int TimeW = ptst_pkg::TimeW;

   logic [TimeW-1:0] ticks_ff;
   logic [TimeW-1:0] ticks_in;
   logic [TimeW-1:0] epochs_ff;
   logic [TimeW-1:0] epochs_in;
   logic             lt;
   logic             eq;

   always_comb begin
      ticks_in  = ticks_ff;
      epochs_in = epochs_ff;
      if (tick) begin
         ticks_in = ticks_ff + TimeW'(1);
         if (ticks_ff == '1) begin
            epochs_in = epochs_ff + TimeW'(1);
         end
      end
   end

   assign lt = ({probe_epochs, probe_ticks} < {epochs_ff, ticks_ff});
   assign eq = ({probe_epochs, probe_ticks} == {epochs_ff, ticks_ff});

   always_comb begin
      case (mode)
         ptst_pkg::CMP_EQ: compare_true = eq;
         ptst_pkg::CMP_LT: compare_true = lt;
         ptst_pkg::CMP_LE: compare_true = lt || eq;
         ptst_pkg::CMP_GT: compare_true = !lt && !eq;
         ptst_pkg::CMP_GE: compare_true = !lt;
         default:          compare_true = 1'b0;
      endcase
   end

   assign now_epochs = epochs_ff;
   assign now_ticks  = ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= '0;
         epochs_ff <= '0;
      end else begin
         ticks_ff  <= ticks_in;
         epochs_ff <= epochs_in;
      end
   end

endmodule

@@ hw/rtl/periodic_timer_slot_table_core.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_slot_table_core: table of periodic timer slots
// Millisecond timestamp plus SLOT_COUNT reloading countdown slots.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge with start high and busy low; busy
// stays low, so a word can be taken on every cycle. Operations are tick, add,
// remove, set enable, set interval, query and compare to now.
// Each word yields exactly one result word, shown on the rsp_ ports for one
// cycle with rsp_valid high, from the result register: the edge that took the
// command loads the input register, the next updates the timestamp, slot bank
// and free stack together and loads the result register. Throughput is one
// word per cycle; the parallel update of all countdowns sets the clock rate.
// The rsp_now_ fields show the timestamp as left by the word being reported.
// The receiver cannot stall; a result is gone after its one strobe cycle.
// Reset (synchronous, active high) clears the timestamp, marks every slot free
// and disabled, and fills the free stack with handle 0 on top. Slot periods and
// countdowns are not reset; they are written when a slot is added.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table_core #(
   parameter int SLOT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [2:0]  req_slot,
   input  logic [31:0] req_interval,
   input  logic        req_enable_flag,
   input  logic [2:0]  req_compare_mode,
   input  logic [31:0] req_probe_epochs,
   input  logic [31:0] req_probe_ticks,
   output logic        rsp_valid,
   output logic [7:0]  rsp_fire_mask,
   output logic        rsp_success,
   output logic [2:0]  rsp_slot_out,
   output logic [31:0] rsp_prev_interval,
   output logic        rsp_prev_enabled,
   output logic [31:0] rsp_now_epochs,
   output logic [31:0] rsp_now_ticks,
   output logic        rsp_compare_true
);

   localparam int SlotW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TimeW   = ptst_pkg::TimeW;
   localparam int FireW   = ptst_pkg::FireW;
   localparam int HandleW = ptst_pkg::HandleW;

   logic                       accept;
   logic                       req_valid_ff;
   ptst_pkg::op_type           op_ff;
   logic [HandleW-1:0]         slot_ff;
   logic [TimeW-1:0]           interval_ff;
   logic                       enable_ff;
   ptst_pkg::cmp_mode_type     mode_ff;
   logic [TimeW-1:0]           probe_epochs_ff;
   logic [TimeW-1:0]           probe_ticks_ff;

   logic                       slot_ok;
   logic [SlotW-1:0]           sel_slot;
   logic [SlotW-1:0]           top_slot;
   logic                       can_pop;
   logic                       can_push;
   logic                       pop;
   logic                       push;
   ptst_pkg::bank_cmd_type     cmd;
   logic                       sel_in_use;
   logic                       sel_enabled;
   logic [TimeW-1:0]           sel_period;
   logic [FireW-1:0]           fire_mask;
   logic                       compare_true;

   logic                       rsp_valid_ff;
   logic [FireW-1:0]           fire_ff;
   logic [FireW-1:0]           fire_in;
   logic                       success_ff;
   logic                       success_in;
   logic [HandleW-1:0]         slot_out_ff;
   logic [HandleW-1:0]         slot_out_in;
   logic [TimeW-1:0]           prev_interval_ff;
   logic [TimeW-1:0]           prev_interval_in;
   logic                       prev_enabled_ff;
   logic                       prev_enabled_in;
   logic                       compare_ff;
   logic                       compare_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff           <= ptst_pkg::op_type'(req_operation);
         slot_ff         <= req_slot;
         interval_ff     <= req_interval;
         enable_ff       <= req_enable_flag;
         mode_ff         <= ptst_pkg::cmp_mode_type'(req_compare_mode);
         probe_epochs_ff <= req_probe_epochs;
         probe_ticks_ff  <= req_probe_ticks;
      end
   end

   assign slot_ok  = (32'(slot_ff) < SLOT_COUNT);
   assign sel_slot = SlotW'(slot_ff);

   // Decode: every result field that does not belong to the operation is zero.
   always_comb begin
      cmd              = '0;
      cmd.enable_value = enable_ff;
      cmd.period_value = interval_ff;
      pop              = 1'b0;
      push             = 1'b0;
      success_in       = 1'b0;
      slot_out_in      = '0;
      prev_interval_in = '0;
      prev_enabled_in  = 1'b0;
      compare_in       = 1'b0;
      if (req_valid_ff) begin
         case (op_ff)
            ptst_pkg::OP_TICK: begin
               cmd.tick = 1'b1;
            end
            ptst_pkg::OP_ADD: begin
               if (can_pop && (interval_ff != '0)) begin
                  pop         = 1'b1;
                  cmd.alloc   = 1'b1;
                  success_in  = 1'b1;
                  slot_out_in = HandleW'(top_slot);
               end
            end
            ptst_pkg::OP_REMOVE: begin
               if (slot_ok && sel_in_use && can_push) begin
                  push       = 1'b1;
                  cmd.free   = 1'b1;
                  success_in = 1'b1;
               end
            end
            ptst_pkg::OP_SET_ENABLE: begin
               if (slot_ok) begin
                  prev_enabled_in = sel_enabled;
                  cmd.set_enable  = 1'b1;
               end
            end
            ptst_pkg::OP_SET_INTERVAL: begin
               if (slot_ok) begin
                  prev_interval_in = sel_period;
                  cmd.set_period   = (interval_ff != '0);
               end
            end
            ptst_pkg::OP_QUERY: begin
               if (slot_ok) begin
                  prev_interval_in = sel_period;
                  prev_enabled_in  = sel_enabled;
               end
            end
            ptst_pkg::OP_COMPARE: begin
               compare_in = compare_true;
            end
            default: begin
            end
         endcase
      end
   end

   assign fire_in = fire_mask;

   ptst_free_stack #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .push      (push),
      .push_slot (sel_slot),
      .top_slot  (top_slot),
      .can_pop   (can_pop),
      .can_push  (can_push)
   );

   ptst_slot_bank #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_slot_bank (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .alloc_slot  (top_slot),
      .sel_slot    (sel_slot),
      .sel_in_use  (sel_in_use),
      .sel_enabled (sel_enabled),
      .sel_period  (sel_period),
      .fire_mask   (fire_mask)
   );

   ptst_timebase u_timebase (
      .clock        (clock),
      .reset        (reset),
      .tick         (cmd.tick),
      .mode         (mode_ff),
      .probe_epochs (probe_epochs_ff),
      .probe_ticks  (probe_ticks_ff),
      .now_epochs   (rsp_now_epochs),
      .now_ticks    (rsp_now_ticks),
      .compare_true (compare_true)
   );

   // Result register. The timestamp is read straight from the timebase, which
   // changes on the same edge as the result register and so lines up with it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      fire_ff          <= fire_in;
      success_ff       <= success_in;
      slot_out_ff      <= slot_out_in;
      prev_interval_ff <= prev_interval_in;
      prev_enabled_ff  <= prev_enabled_in;
      compare_ff       <= compare_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fire_mask     = fire_ff;
   assign rsp_success       = success_ff;
   assign rsp_slot_out      = slot_out_ff;
   assign rsp_prev_interval = prev_interval_ff;
   assign rsp_prev_enabled  = prev_enabled_ff;
   assign rsp_compare_true  = compare_ff;

   a_one_result_per_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted word produced no result strobe");

   a_fire_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && (op_ff != ptst_pkg::OP_TICK) |=> (rsp_fire_mask == '0))
      else $error("fire mask set by a non-tick word");

   a_tick_advances_time: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && (op_ff == ptst_pkg::OP_TICK)
      |=> (rsp_now_ticks == $past(rsp_now_ticks) + TimeW'(1)))
      else $error("tick did not advance the tick word by one");

   a_time_holds_otherwise: assert property (@(posedge clock) disable iff (reset)
      !(req_valid_ff && (op_ff == ptst_pkg::OP_TICK))
      |=> $stable(rsp_now_ticks) && $stable(rsp_now_epochs))
      else $error("timestamp moved without a tick");

endmodule
